// File: rtl/stb_pkg.sv
package stb_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RESULT_LIMIT    = 16;
  localparam int IDX_W           = 4;
  localparam int TIMEOUT_W       = 32;
  localparam int RES_CNT_W       = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_RESET  = 3'd3,
    OP_START  = 3'd4,
    OP_STOP   = 3'd5
  } stb_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_SCAN,
    ST_DRAIN
  } stb_state_t;

  // scan side to result queue
  typedef struct packed {
    logic             start;
    logic             push;
    logic [IDX_W-1:0] idx;
    logic             flush;
  } stb_rq_req_t;

  // result queue back to scan side
  typedef struct packed {
    logic stall;
    logic drained;
  } stb_rq_st_t;

endpackage

// File: rtl/stb_if.sv
interface stb_in_if import stb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           opcode;
  logic [IDX_W-1:0]     timer_index;
  logic                 periodic;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  modport source (output valid, opcode, timer_index, periodic, timeout_ticks, input ready);
  modport sink   (input valid, opcode, timer_index, periodic, timeout_ticks, output ready);
endinterface

interface stb_out_if import stb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] expired_index;
  logic             last_expiry;

  modport source (output valid, expired_index, last_expiry, input ready);
  modport sink   (input valid, expired_index, last_expiry, output ready);
endinterface

// File: rtl/stb_slot_mem.sv
module stb_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/stb_result_q.sv
module stb_result_q import stb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  stb_rq_req_t req,
  output stb_rq_st_t  st,
  stb_out_if.source   out_if
);

  logic [RES_CNT_W-1:0] cnt_r;
  logic                 pend_v_r;
  logic [IDX_W-1:0]     pend_idx_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_last_r;
  logic                 out_free;
  logic                 take;
  logic                 flush_mv;
  logic                 load_out;

  assign out_free = !out_valid_r || out_if.ready;
  // requests beyond the per-tick limit are dropped
  assign take     = req.push && (cnt_r < RES_CNT_W'(RESULT_LIMIT));
  assign flush_mv = req.flush && pend_v_r && out_free;
  assign load_out = (take && pend_v_r && out_free) || flush_mv;

  assign st.stall   = take && pend_v_r && !out_free;
  assign st.drained = !pend_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (req.start) begin
        cnt_r <= '0;
      end else if (take && !st.stall) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (take && !st.stall) begin
        pend_v_r <= 1'b1;
      end else if (flush_mv) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !st.stall) begin
      pend_idx_r <= req.idx;
    end
    if (load_out) begin
      out_idx_r  <= pend_idx_r;
      out_last_r <= req.flush;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.expired_index = out_idx_r;
  assign out_if.last_expiry   = out_last_r;

endmodule

// File: rtl/stb_ctrl.sv
module stb_ctrl import stb_pkg::*; #(
  parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  localparam int MEM_W      = 2 * COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  stb_in_if.sink            in_if,
  output logic              mem_rd_en,
  output logic [SLOT_W-1:0] mem_rd_addr,
  input  logic [MEM_W-1:0]  mem_rd_data,
  output logic              mem_wr_en,
  output logic [SLOT_W-1:0] mem_wr_addr,
  output logic [MEM_W-1:0]  mem_wr_data,
  output stb_rq_req_t       rq_req,
  input  stb_rq_st_t        rq_st
);

  localparam int EXT_W = SLOT_W + IDX_W;

  stb_state_t            state_r, state_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [NUM_TIMERS-1:0] present_r, present_nxt;
  logic [NUM_TIMERS-1:0] running_r, running_nxt;
  logic [NUM_TIMERS-1:0] periodic_r, periodic_nxt;

  logic [EXT_W-1:0]       idx_ext;
  logic [EXT_W-1:0]       slot_ext;
  logic [SLOT_W-1:0]      idx_slot;
  logic                   idx_ok;
  logic [COUNT_WIDTH-1:0] tv;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] cur_rel;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   active;
  logic                   hit;
  logic                   last_slot;

  assign idx_ext   = EXT_W'(in_if.timer_index);
  assign idx_slot  = idx_ext[SLOT_W-1:0];
  assign idx_ok    = (32'(in_if.timer_index) < 32'(NUM_TIMERS));
  assign tv        = COUNT_WIDTH'(in_if.timeout_ticks);
  assign cur_cnt   = mem_rd_data[COUNT_WIDTH-1:0];
  assign cur_rel   = mem_rd_data[MEM_W-1:COUNT_WIDTH];
  // zero wraps to all ones, so it only expires after a full period
  assign dec       = cur_cnt - COUNT_WIDTH'(1);
  assign active    = present_r[slot_r] && running_r[slot_r];
  assign hit       = active && (dec == '0);
  assign last_slot = (slot_r == SLOT_W'(NUM_TIMERS - 1));
  assign slot_ext  = EXT_W'(slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      slot_r     <= '0;
      present_r  <= '0;
      running_r  <= '0;
      periodic_r <= '0;
    end else begin
      state_r    <= state_nxt;
      slot_r     <= slot_nxt;
      present_r  <= present_nxt;
      running_r  <= running_nxt;
      periodic_r <= periodic_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    present_nxt  = present_r;
    running_nxt  = running_r;
    periodic_nxt = periodic_r;
    in_if.ready  = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = idx_slot;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = slot_r;
    mem_wr_data  = {cur_rel, dec};
    rq_req       = '0;
    rq_req.idx   = slot_ext[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          case (stb_op_t'(in_if.opcode))
            OP_TICK: begin
              mem_rd_en    = 1'b1;
              mem_rd_addr  = '0;
              slot_nxt     = '0;
              rq_req.start = 1'b1;
              state_nxt    = ST_SCAN;
            end
            OP_CREATE: begin
              if (idx_ok) begin
                mem_wr_en              = 1'b1;
                mem_wr_addr            = idx_slot;
                mem_wr_data            = {tv, tv};
                present_nxt[idx_slot]  = 1'b1;
                running_nxt[idx_slot]  = 1'b1;
                periodic_nxt[idx_slot] = in_if.periodic;
              end
            end
            OP_DELETE: begin
              if (idx_ok) begin
                present_nxt[idx_slot]  = 1'b0;
                running_nxt[idx_slot]  = 1'b0;
                periodic_nxt[idx_slot] = 1'b0;
              end
            end
            OP_RESET: begin
              if (idx_ok) begin
                mem_rd_en = 1'b1;
                slot_nxt  = idx_slot;
                state_nxt = ST_RELOAD;
              end
            end
            OP_START: begin
              if (idx_ok) begin
                running_nxt[idx_slot] = 1'b1;
              end
            end
            OP_STOP: begin
              if (idx_ok) begin
                running_nxt[idx_slot] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RELOAD: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {cur_rel, cur_rel};
        state_nxt   = ST_IDLE;
      end
      ST_SCAN: begin
        rq_req.push = hit;
        // hold this slot and its read data while the result side is full
        if (!rq_st.stall) begin
          if (active) begin
            mem_wr_en = 1'b1;
          end
          if (hit) begin
            if (periodic_r[slot_r]) begin
              mem_wr_data = {cur_rel, cur_rel};
            end else begin
              present_nxt[slot_r]  = 1'b0;
              running_nxt[slot_r]  = 1'b0;
              periodic_nxt[slot_r] = 1'b0;
            end
          end
          if (last_slot) begin
            state_nxt = ST_DRAIN;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = slot_r + 1'b1;
            slot_nxt    = slot_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        rq_req.flush = 1'b1;
        if (rq_st.drained) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/software_timer_bank_top.sv
// tick: one slot per cycle through the slot memory read port, the scan holding its slot
//   while a result waits on a full output register
// create, delete, start, stop: complete when accepted; reset count: read then write back
// an expiry is held until the next expiry or the end of the scan; results keep slot order
// reset: slot flags, scan state and result registers clear at once; no clearing pass,
//   count memory only matters for slots whose present bit is set
module software_timer_bank_top import stb_pkg::*; #(
  parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  stb_in_if.sink     in_if,
  stb_out_if.source  out_if
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MEM_W  = 2 * COUNT_WIDTH;

  logic              mem_rd_en;
  logic [SLOT_W-1:0] mem_rd_addr;
  logic [MEM_W-1:0]  mem_rd_data;
  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_addr;
  logic [MEM_W-1:0]  mem_wr_data;
  stb_rq_req_t       rq_req;
  stb_rq_st_t        rq_st;

  stb_ctrl #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .rq_req      (rq_req),
    .rq_st       (rq_st)
  );

  stb_slot_mem #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (MEM_W),
    .AW    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  stb_result_q u_rq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rq_req),
    .st     (rq_st),
    .out_if (out_if)
  );

  // write-back never lands on the slot being read in the same cycle
  a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("slot memory read and write hit the same entry");

  // results are only produced while a tick scans, never while requests are taken
  a_no_push_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> (!rq_req.push && !rq_req.flush))
    else $error("result request while accepting input");

  // a push and the end-of-tick flush never overlap
  a_push_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rq_req.push && rq_req.flush))
    else $error("push and flush in the same cycle");

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stb_pkg::*;

  localparam int NT          = NUM_TIMERS_DEF;
  localparam int CW          = COUNT_WIDTH_DEF;
  localparam int DIR_N       = 25;
  localparam int RAND_ITEMS  = 425;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 40;
  localparam int MAX_REPORTS = 10;

  // opcodes the block has no meaning for
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]           op;
    logic [IDX_W-1:0]     idx;
    logic                 per;
    logic [TIMEOUT_W-1:0] ticks;
  } timer_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } expiry_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [IDX_W-1:0]     idx;
    logic                 per;
    logic [TIMEOUT_W-1:0] ticks;
    logic                 typed;
    logic [NT-1:0]        fired;
  } dir_row_t;

  logic clk;
  logic rst_n;

  stb_in_if  in_ch ();
  stb_out_if out_ch ();

  software_timer_bank_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // predicted slot state
  bit            slot_on     [NT];
  bit            slot_run    [NT];
  bit            slot_cyc    [NT];
  logic [CW-1:0] slot_reload [NT];
  logic [CW-1:0] slot_count  [NT];

  expiry_t  expiry_q [$];
  int       error_count  = 0;
  int       results_seen = 0;
  dir_row_t dir_rows [DIR_N];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_slot(int s);
    slot_on[s]     = 1'b0;
    slot_run[s]    = 1'b0;
    slot_cyc[s]    = 1'b0;
    slot_reload[s] = '0;
    slot_count[s]  = '0;
  endfunction

  // updates the slot state and returns the slots that expire
  function automatic logic [NT-1:0] apply_request(timer_req_t r);
    logic [NT-1:0] fired;
    int            s;
    fired = '0;
    if (r.op == OP_TICK) begin
      for (s = 0; s < NT; s++) begin
        if (slot_on[s] && slot_run[s]) begin
          slot_count[s] = slot_count[s] - 1'b1;
          if (slot_count[s] == '0) begin
            fired[s] = 1'b1;
            if (slot_cyc[s]) begin
              slot_count[s] = slot_reload[s];
            end else begin
              clear_slot(s);
            end
          end
        end
      end
    end else if (int'(r.idx) < NT) begin
      s = int'(r.idx);
      case (r.op)
        OP_CREATE: begin
          slot_on[s]     = 1'b1;
          slot_run[s]    = 1'b1;
          slot_cyc[s]    = r.per;
          slot_reload[s] = CW'(r.ticks);
          slot_count[s]  = CW'(r.ticks);
        end
        OP_DELETE: clear_slot(s);
        OP_RESET:  slot_count[s] = slot_reload[s];
        OP_START:  slot_run[s] = 1'b1;
        OP_STOP:   slot_run[s] = 1'b0;
        default: ;
      endcase
    end
    return fired;
  endfunction

  function automatic void queue_expiries(logic [NT-1:0] fired);
    int      s;
    int      n;
    expiry_t e;
    n = 0;
    for (s = 0; s < NT; s++) begin
      if (fired[s] && n < RESULT_LIMIT) begin
        e.idx  = IDX_W'(s);
        e.last = 1'b0;
        expiry_q.push_back(e);
        n++;
      end
    end
    if (n > 0) begin
      e = expiry_q.pop_back();
      e.last = 1'b1;
      expiry_q.push_back(e);
    end
  endfunction

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIMEOUT_W-1:0] timeout_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 6);
    if (pick < 80) return $urandom_range(7, 40);
    if (pick < 88) return '0;
    if (pick < 92) return '1;
    return $urandom;
  endfunction

  function automatic timer_req_t random_request();
    timer_req_t r;
    int         pick;
    pick    = $urandom_range(0, 99);
    r.idx   = IDX_W'($urandom_range(0, 15));
    r.per   = 1'($urandom_range(0, 1));
    r.ticks = $urandom;
    if (pick < 40) begin
      r.op = OP_TICK;
    end else if (pick < 68) begin
      r.op    = OP_CREATE;
      r.ticks = timeout_value();
    end else if (pick < 75) begin
      r.op = OP_DELETE;
    end else if (pick < 82) begin
      r.op = OP_RESET;
    end else if (pick < 89) begin
      r.op = OP_START;
    end else if (pick < 96) begin
      r.op = OP_STOP;
    end else begin
      r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
    end
    return r;
  endfunction

  // drives one request, predicts at the edge that accepts it
  task automatic send_request(input timer_req_t r, input int gap, input bit typed,
                              input logic [NT-1:0] typed_fired);
    logic [NT-1:0] fired;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode        = r.op;
    in_ch.timer_index   = r.idx;
    in_ch.periodic      = r.per;
    in_ch.timeout_ticks = r.ticks;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    fired = apply_request(r);
    queue_expiries(typed ? typed_fired : fired);
    @(negedge clk);
  endtask

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_results
    expiry_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expiry_q.size() == 0) begin
        note_failure($sformatf("unexpected expiry idx=%0d last=%0b",
                               out_ch.expired_index, out_ch.last_expiry));
      end else begin
        e = expiry_q.pop_front();
        if (out_ch.expired_index !== e.idx || out_ch.last_expiry !== e.last) begin
          note_failure($sformatf("expiry mismatch: idx exp %0d got %0d, last exp %0b got %0b",
                                 e.idx, out_ch.expired_index, e.last, out_ch.last_expiry));
        end
      end
    end
  end

  // result side: random stalls, calm stretches, one long hold-off
  initial begin
    int     stall_left;
    int     hold_left;
    bit     held;
    longint cyc;
    stall_left   = 0;
    hold_left    = 0;
    held         = 1'b0;
    cyc          = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (cyc % 600 < 150) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        if ($urandom_range(0, 99) < 20) stall_left = idle_length();
      end
    end
  end

  initial begin
    timer_req_t r;
    int         n_items;
    int         s;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_TICK;
    in_ch.timer_index   = '0;
    in_ch.periodic      = 1'b0;
    in_ch.timeout_ticks = '0;

    dir_rows = '{
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h0000},  // nothing after reset
      '{OP_CREATE, 4'd0,  1'b0, 32'd1,         1'b0, 16'h0000},
      '{OP_CREATE, 4'd15, 1'b1, 32'd2,         1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h0001},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h8000},
      '{OP_CREATE, 4'd5,  1'b1, 32'd0,         1'b0, 16'h0000},  // zero count wraps
      '{OP_CREATE, 4'd7,  1'b0, 32'hFFFF_FFFF, 1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h0000},
      '{OP_STOP,   4'd15, 1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h0000},
      '{OP_START,  4'd15, 1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_RESET,  4'd15, 1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_START,  4'd3,  1'b0, 32'd0,         1'b0, 16'h0000},  // running but not present
      '{OP_RESET,  4'd3,  1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h8000},
      '{OP_DELETE, 4'd5,  1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_SPARE6, 4'd2,  1'b1, 32'hAAAA_5555, 1'b0, 16'h0000},
      '{OP_SPARE7, 4'd9,  1'b0, 32'h5555_AAAA, 1'b0, 16'h0000},
      '{OP_CREATE, 4'd15, 1'b0, 32'd1,         1'b0, 16'h0000},  // overwrite a live slot
      '{OP_CREATE, 4'd3,  1'b1, 32'd1,         1'b0, 16'h0000},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h8008},
      '{OP_TICK,   4'd0,  1'b0, 32'd0,         1'b1, 16'h0008},
      '{OP_DELETE, 4'd3,  1'b0, 32'd0,         1'b0, 16'h0000},
      '{OP_DELETE, 4'd7,  1'b0, 32'd0,         1'b0, 16'h0000}
    };

    for (s = 0; s < NT; s++) clear_slot(s);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      r.op    = dir_rows[i].op;
      r.idx   = dir_rows[i].idx;
      r.per   = dir_rows[i].per;
      r.ticks = dir_rows[i].ticks;
      send_request(r, idle_length(), dir_rows[i].typed, dir_rows[i].fired);
    end

    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      if ($urandom_range(0, 24) == 0) begin
        // fill every slot with a short count so ticks fire many expiries
        for (s = 0; s < NT; s++) begin
          r.op    = OP_CREATE;
          r.idx   = IDX_W'(s);
          r.per   = 1'($urandom_range(0, 1));
          r.ticks = $urandom_range(1, 3);
          send_request(r, idle_length(), 1'b0, '0);
        end
        repeat (3) begin
          r     = random_request();
          r.op  = OP_TICK;
          send_request(r, 0, 1'b0, '0);
        end
        n_items += NT + 3;
      end else begin
        r = random_request();
        send_request(r, ((n_items / 60) % 3 == 2) ? 0 : idle_length(), 1'b0, '0);
        n_items++;
      end
    end
    in_ch.valid = 1'b0;

    while (expiry_q.size() != 0) @(posedge clk);
    repeat (4 * (NT + 2)) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
